// ===== hw/rtl/fms_pkg.sv =====
// fms_pkg: shared types, constants and character helpers for the fuzzy match scorer
// no dependencies; imported by every module of the block
package fms_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int MAX_TEXT    = 4096;

    localparam int CHAR_W  = 8;
    localparam int SCORE_W = 14;
    localparam int WIDE_W  = 16;
    localparam int BONUS_W = 6;
    localparam int POS_W   = $clog2(MAX_TEXT + 2);
    localparam int ROW_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int PLEN_W  = 5;

    localparam int FIRST_BONUS = 15;
    localparam int SEP_BONUS   = 30;
    localparam int CAMEL_BONUS = 30;
    localparam int LEAD_STEP   = -5;
    localparam int LEAD_CAP    = -15;
    localparam int SEQ_BONUS   = 15;
    localparam int BASE_SCORE  = 100;
    localparam int CASE_OFFSET = 32;

    typedef enum logic [1:0] {
        CFG_PATTERN_LENGTH = 2'd0,
        CFG_CHARS_LOW      = 2'd1,
        CFG_CHARS_HIGH     = 2'd2
    } cfg_index_t;

    typedef logic signed [SCORE_W-1:0] score_t;
    typedef logic signed [WIDE_W-1:0]  wide_t;

    // per-column information shared by all cells
    typedef struct packed {
        logic [CHAR_W-1:0]  lc;
        logic [BONUS_W-1:0] bonus;
        logic [POS_W-1:0]   pos;
        logic               active;
        score_t             head_score;
    } col_info_t;

    // old column values handed from a cell to its upper neighbour
    typedef struct packed {
        logic   direct;
        score_t score;
        logic   score_valid;
        score_t best;
        logic   best_valid;
    } cell_link_t;

    typedef struct packed {
        score_t score;
        logic   valid;
    } row_next_t;

    function automatic logic [CHAR_W-1:0] to_lower(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
            r = c + CHAR_W'(CASE_OFFSET);
        return r;
    endfunction

    function automatic logic is_sep(input logic [CHAR_W-1:0] c);
        return (c == 8'h20) || (c == 8'h2D) || (c == 8'h5F) || (c == 8'h2E) ||
               (c == 8'h2C) || (c == 8'h3A) || (c == 8'h27) || (c == 8'h2F);
    endfunction

    function automatic wide_t widen(input score_t v);
        return {{(WIDE_W-SCORE_W){v[SCORE_W-1]}}, v};
    endfunction

endpackage

// ===== hw/rtl/fms_column.sv =====
// fms_column: text position, previous character, bonuses and the row 0 seed score
// depends on fms_pkg
module fms_column
    import fms_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              clear,
    input  logic [CHAR_W-1:0] text_char,
    output col_info_t         col
);

    logic [CHAR_W-1:0] prev_char_reg;
    logic [POS_W-1:0]  pos_reg;

    logic               first;
    logic               camel;
    logic [BONUS_W-1:0] bonus;
    wide_t              pos_w;
    wide_t              lead;
    wide_t              head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_char_reg <= '0;
            pos_reg       <= '0;
        end
        else if (clear)
        begin
            prev_char_reg <= '0;
            pos_reg       <= '0;
        end
        else if (step)
        begin
            prev_char_reg <= text_char;
            if (pos_reg <= POS_W'(MAX_TEXT))
                pos_reg <= pos_reg + 1'b1;
        end
    end

    always_comb
    begin
        first = (pos_reg == '0);
        camel = (prev_char_reg >= 8'h61) && (prev_char_reg <= 8'h7A) &&
                (text_char >= 8'h41) && (text_char <= 8'h5A);
        bonus = '0;
        if (!first)
        begin
            if (is_sep(prev_char_reg))
                bonus = bonus + BONUS_W'(SEP_BONUS);
            if (camel)
                bonus = bonus + BONUS_W'(CAMEL_BONUS);
        end
        pos_w = {{(WIDE_W-POS_W){1'b0}}, pos_reg};
        // leading penalty grows per character until it hits the cap
        if (pos_reg >= POS_W'(3))
            lead = WIDE_W'(LEAD_CAP);
        else
            lead = WIDE_W'(LEAD_STEP) * pos_w;
        if (first)
            head = WIDE_W'(FIRST_BONUS) + lead - pos_w;
        else
            head = {{(WIDE_W-BONUS_W){1'b0}}, bonus} + lead - pos_w;

        col.lc         = to_lower(text_char);
        col.bonus      = bonus;
        col.pos        = pos_reg;
        col.active     = (pos_reg < POS_W'(MAX_TEXT));
        col.head_score = head[SCORE_W-1:0];
    end

endmodule

// ===== hw/rtl/fms_cell.sv =====
// fms_cell: one pattern row, last column score and running best of score plus position
// depends on fms_pkg
module fms_cell
    import fms_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              clear,
    input  col_info_t         col,
    input  logic [CHAR_W-1:0] pat_char,
    input  cell_link_t        link_in,
    output cell_link_t        link_out,
    output row_next_t         row_next
);

    score_t last_reg;
    logic   last_valid_reg;
    score_t best_reg;
    logic   best_valid_reg;

    score_t best_next;
    logic   best_valid_next;
    wide_t  fold;
    wide_t  pos_w;
    wide_t  bonus_w;
    wide_t  seq_cand;
    wide_t  gap_cand;
    wide_t  ns;
    logic   nv;
    logic   hit;

    always_comb
    begin
        pos_w   = {{(WIDE_W-POS_W){1'b0}}, col.pos};
        bonus_w = {{(WIDE_W-BONUS_W){1'b0}}, col.bonus};

        // fold previous column into the running best
        fold            = widen(last_reg) + pos_w - 16'sd1;
        best_next       = best_reg;
        best_valid_next = best_valid_reg;
        if (last_valid_reg && (!best_valid_reg || fold > widen(best_reg)))
        begin
            best_next       = fold[SCORE_W-1:0];
            best_valid_next = 1'b1;
        end

        seq_cand = widen(link_in.score) + bonus_w + WIDE_W'(SEQ_BONUS);
        gap_cand = widen(link_in.best) + bonus_w - pos_w + 16'sd1;
        hit      = (to_lower(pat_char) == col.lc);
        ns       = '0;
        nv       = 1'b0;
        if (hit)
        begin
            if (link_in.direct)
            begin
                ns = widen(link_in.score);
                nv = 1'b1;
            end
            else
            begin
                if (link_in.score_valid)
                begin
                    ns = seq_cand;
                    nv = 1'b1;
                end
                if (link_in.best_valid && (!nv || gap_cand > ns))
                begin
                    ns = gap_cand;
                    nv = 1'b1;
                end
            end
        end

        row_next.score = ns[SCORE_W-1:0];
        row_next.valid = nv;

        link_out.direct      = 1'b0;
        link_out.score       = last_reg;
        link_out.score_valid = last_valid_reg;
        link_out.best        = best_reg;
        link_out.best_valid  = best_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_valid_reg <= 1'b0;
            best_valid_reg <= 1'b0;
        end
        else if (clear)
        begin
            last_valid_reg <= 1'b0;
            best_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            last_valid_reg <= nv;
            best_valid_reg <= best_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            last_reg <= ns[SCORE_W-1:0];
            best_reg <= best_next;
        end
    end

endmodule

// ===== hw/rtl/fuzzy_match_scorer.sv =====
// fuzzy_match_scorer: top level, configuration registers, chain of row cells,
// final score tracking and the result register; depends on fms_pkg, fms_column, fms_cell
//
// channel  direction  handshake               payload
// cfg      in         cfg_valid / cfg_ready   cfg_index, cfg_data
// in       in         in_valid / in_ready     text_char, last_char
// out      out        out_valid / out_ready   matched, score, text_too_long
//
// one text character per cycle: below the text limit every row cell updates in the cycle
// of the transfer, the longest path being the column bonus, one cell's add and compare,
// the final row select and compare and the base score add into the result register
// the result appears in the cycle after the transfer of the last character
// a last character stalls only while an earlier result is still waiting; other
// characters are taken regardless of the output side
// reset clears the text state and the pattern registers; no clearing pass is needed
module fuzzy_match_scorer
    import fms_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [63:0]               cfg_data,

    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [CHAR_W-1:0]         text_char,
    input  logic                      last_char,

    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      matched,
    output logic signed [SCORE_W-1:0] score,
    output logic                      text_too_long
);

    // configuration registers
    logic [PLEN_W-1:0] pattern_length_reg;
    logic [63:0]       pattern_low_reg;
    logic [63:0]       pattern_high_reg;
    logic [127:0]      pattern_all;

    // result register
    logic               out_valid_reg;
    logic               matched_reg;
    score_t             score_reg;
    logic               too_long_reg;

    // final row tracking
    score_t             best_final_reg;
    logic               final_valid_reg;
    score_t             best_final_next;
    logic               final_valid_next;

    logic               accept;
    logic               step;
    logic               clear;
    logic               plen_ok;
    logic [ROW_W-1:0]   sel_row;
    row_next_t          sel_next;
    logic               too_long;
    logic               len_ok;
    logic               ok;
    wide_t              final_sum;

    col_info_t          col;
    cell_link_t         link_w [MAX_PATTERN];
    row_next_t          row_w  [MAX_PATTERN];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= '0;
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[PLEN_W-1:0];
                CFG_CHARS_LOW:      pattern_low_reg    <= cfg_data;
                CFG_CHARS_HIGH:     pattern_high_reg   <= cfg_data;
                default:            ;   // unmapped index, write dropped
            endcase
        end
    end

    assign pattern_all = {pattern_high_reg, pattern_low_reg};

    // a last character must wait for the result register to free up
    assign in_ready = !out_valid_reg || out_ready || !last_char;
    assign accept   = in_valid && in_ready;
    assign step     = accept && col.active;
    assign clear    = accept && last_char;

    fms_column u_column
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (accept),
        .clear     (clear),
        .text_char (text_char),
        .col       (col)
    );

    // row 0 takes its score straight from the column seed
    assign link_w[0] = '{direct: 1'b1, score: col.head_score, score_valid: 1'b1,
                         best: '0, best_valid: 1'b0};

    for (genvar i = 0; i < MAX_PATTERN; i++)
    begin : g_cell
        if (i < MAX_PATTERN - 1)
        begin : g_mid
            fms_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .step     (step),
                .clear    (clear),
                .col      (col),
                .pat_char (pattern_all[i*CHAR_W +: CHAR_W]),
                .link_in  (link_w[i]),
                .link_out (link_w[i+1]),
                .row_next (row_w[i])
            );
        end
        else
        begin : g_top
            fms_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .step     (step),
                .clear    (clear),
                .col      (col),
                .pat_char (pattern_all[i*CHAR_W +: CHAR_W]),
                .link_in  (link_w[i]),
                .link_out (),
                .row_next (row_w[i])
            );
        end
    end

    always_comb
    begin
        plen_ok  = (pattern_length_reg != '0) &&
                   (pattern_length_reg <= PLEN_W'(MAX_PATTERN));
        sel_row  = ROW_W'(pattern_length_reg - 1'b1);
        sel_next = row_w[sel_row];

        // best score of the final row over all columns so far
        best_final_next  = best_final_reg;
        final_valid_next = final_valid_reg;
        if (step && plen_ok && sel_next.valid &&
            (!final_valid_reg || sel_next.score > best_final_reg))
        begin
            best_final_next  = sel_next.score;
            final_valid_next = 1'b1;
        end

        // position after this character passes the limit
        too_long  = (col.pos >= POS_W'(MAX_TEXT));
        len_ok    = ({{(POS_W-PLEN_W){1'b0}}, pattern_length_reg} <= (col.pos + 1'b1));
        ok        = !too_long && final_valid_next && plen_ok && len_ok;
        final_sum = widen(best_final_next) + WIDE_W'(BASE_SCORE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            final_valid_reg <= 1'b0;
        else if (clear)
            final_valid_reg <= 1'b0;
        else
            final_valid_reg <= final_valid_next;
    end

    always_ff @(posedge clk)
    begin
        best_final_reg <= best_final_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (clear)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (clear)
        begin
            matched_reg  <= ok;
            score_reg    <= ok ? final_sum[SCORE_W-1:0] : '0;
            too_long_reg <= too_long;
        end
    end

    assign out_valid     = out_valid_reg;
    assign matched       = matched_reg;
    assign score         = score_reg;
    assign text_too_long = too_long_reg;

endmodule

// ===== tb/sv/fuzzy_match_scorer_test.sv =====
`timescale 1ns / 100ps
// fuzzy_match_scorer_test: self-checking testbench for the fuzzy match scorer
// depends on fms_pkg and fuzzy_match_scorer; drives random texts and patterns against
// an in-bench scoring predictor and checks every result transfer field by field
module fuzzy_match_scorer_test;
    import fms_pkg::*;

    localparam int          CYCLE_LIMIT  = 400_000;
    localparam int          RANDOM_ITEMS = 700;
    localparam int          LONG_HOLD    = 400;
    localparam logic [1:0]  CFG_SPARE    = 2'd3;   // index with no register behind it

    // one text byte waiting for the driver
    typedef struct {
        bit [7:0] ch;
        bit       last;
    } text_item_t;

    // the result expected for one finished text
    typedef struct {
        bit     hit;
        score_t total;
        bit     overflow;
    } text_score_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_index = '0;
    logic [63:0]         cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [CHAR_W-1:0]   text_char = '0;
    logic                last_char = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                matched;
    logic signed [SCORE_W-1:0] score;
    logic                text_too_long;

    fuzzy_match_scorer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .text_char     (text_char),
        .last_char     (last_char),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .matched       (matched),
        .score         (score),
        .text_too_long (text_too_long)
    );

    // stimulus side
    text_item_t  text_queue[$];
    bit [7:0]    text_buf[$];
    int          chars_pending = 0;
    int          short_items = 0;
    bit          steady = 1'b0;        // no random idling on either side while set
    bit          stall_phase = 1'b0;   // asks the receiver for one long hold-off
    bit [7:0]    gen_chars[MAX_PATTERN];
    int          gen_len = 0;

    // monitor side
    bit          char_taken = 1'b0;
    bit          reg_written = 1'b0;
    text_score_t awaited_scores[$];
    int          errors = 0;
    int          cycle_count = 0;

    // predictor copy of the registers
    bit [4:0]    pat_len = '0;
    bit [63:0]   pat_lo = '0;
    bit [63:0]   pat_hi = '0;

    // predictor copy of the per-text state
    bit [7:0]    prev_char;
    int          text_pos;
    int          col_score[MAX_PATTERN];
    bit          col_ok[MAX_PATTERN];
    int          run_best[MAX_PATTERN];
    bit          run_best_ok[MAX_PATTERN];
    int          final_best;
    bit          final_ok;

    // receiver hold-off, owned by the out_ready process
    int          hold_left = 0;
    bit          stall_done = 1'b0;

    initial begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // scoring predictor
    // ------------------------------------------------------------------

    function automatic bit [7:0] fold_case(input bit [7:0] c);
        if (c >= "A" && c <= "Z")
            return c + 8'(CASE_OFFSET);
        return c;
    endfunction

    function automatic bit separator(input bit [7:0] c);
        return c == " " || c == "-" || c == "_" || c == "." || c == "," ||
               c == ":" || c == "'" || c == "/";
    endfunction

    // pattern byte of row k as the registers stand now
    function automatic bit [7:0] pattern_at(input int k);
        if (k < 8)
            return pat_lo[8*k +: 8];
        return pat_hi[8*(k-8) +: 8];
    endfunction

    task automatic clear_text();
        prev_char  = '0;
        text_pos   = 0;
        final_best = 0;
        final_ok   = 1'b0;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            col_score[k]   = 0;
            col_ok[k]      = 1'b0;
            run_best[k]    = 0;
            run_best_ok[k] = 1'b0;
        end
    endtask

    // advance the score columns by one text byte; on the last byte queue the result
    task automatic score_char(input bit [7:0] c, input bit last);
        int          j;
        int          bonus;
        int          lead;
        int          cand;
        int          ns;
        int          row;
        bit          nv;
        bit          too_long;
        bit          ok;
        bit [7:0]    lc;
        text_score_t res;
        j = text_pos;
        if (j < MAX_TEXT)
        begin
            bonus = 0;
            lc = fold_case(c);
            if (j > 0)
            begin
                if (separator(prev_char))
                    bonus += SEP_BONUS;
                if (prev_char >= "a" && prev_char <= "z" && c >= "A" && c <= "Z")
                    bonus += CAMEL_BONUS;
            end
            // top row first so that row k-1 still holds the previous column
            for (int k = MAX_PATTERN - 1; k >= 0; k--)
            begin
                nv = 1'b0;
                ns = 0;
                if (col_ok[k])
                begin
                    cand = col_score[k] + j - 1;
                    if (!run_best_ok[k] || cand > run_best[k])
                    begin
                        run_best[k]    = cand;
                        run_best_ok[k] = 1'b1;
                    end
                end
                if (fold_case(pattern_at(k)) == lc)
                begin
                    if (k == 0)
                    begin
                        lead = LEAD_STEP * j;
                        if (lead < LEAD_CAP)
                            lead = LEAD_CAP;
                        ns = ((j == 0) ? FIRST_BONUS : bonus) + lead - j;
                        nv = 1'b1;
                    end
                    else
                    begin
                        if (col_ok[k-1])
                        begin
                            ns = col_score[k-1] + bonus + SEQ_BONUS;
                            nv = 1'b1;
                        end
                        if (run_best_ok[k-1])
                        begin
                            cand = run_best[k-1] + bonus - j + 1;
                            if (!nv || cand > ns)
                                ns = cand;
                            nv = 1'b1;
                        end
                    end
                end
                col_score[k] = ns;
                col_ok[k]    = nv;
            end
            if (pat_len >= 1 && pat_len <= MAX_PATTERN)
            begin
                row = int'(pat_len) - 1;
                if (col_ok[row] && (!final_ok || col_score[row] > final_best))
                begin
                    final_best = col_score[row];
                    final_ok   = 1'b1;
                end
            end
        end
        if (text_pos <= MAX_TEXT)
            text_pos++;
        prev_char = c;
        if (last)
        begin
            too_long = text_pos > MAX_TEXT;
            ok = !too_long && final_ok && pat_len >= 1 && pat_len <= MAX_PATTERN &&
                 int'(pat_len) <= text_pos;
            res.hit      = ok;
            res.total    = ok ? score_t'(BASE_SCORE + final_best) : '0;
            res.overflow = too_long;
            awaited_scores.push_back(res);
            clear_text();
        end
    endtask

    // ------------------------------------------------------------------
    // monitor: register writes, character transfers and result checks
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : watch_ports
        text_score_t want;
        reg_written = rst_n && cfg_valid && cfg_ready;
        char_taken  = rst_n && in_valid && in_ready;

        // results first: a result on this edge always belongs to an earlier text
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_scores.size() == 0)
            begin
                $display("%0t: result transfer with nothing expected (matched %0b score %0d)",
                         $time, matched, score);
                errors++;
            end
            else
            begin
                want = awaited_scores.pop_front();
                if (matched !== want.hit)
                begin
                    $display("%0t: matched expected %0b got %0b", $time, want.hit, matched);
                    errors++;
                end
                if (score !== want.total)
                begin
                    $display("%0t: score expected %0d got %0d", $time, want.total, score);
                    errors++;
                end
                if (text_too_long !== want.overflow)
                begin
                    $display("%0t: text_too_long expected %0b got %0b",
                             $time, want.overflow, text_too_long);
                    errors++;
                end
            end
        end

        if (reg_written)
        begin
            case (cfg_index)
                CFG_PATTERN_LENGTH: pat_len = cfg_data[4:0];
                CFG_CHARS_LOW:      pat_lo  = cfg_data;
                CFG_CHARS_HIGH:     pat_hi  = cfg_data;
                default:            ;   // spare index, write has no effect
            endcase
        end

        // expectation goes in before the pending count drops, so idle waits never
        // see a gap between the two
        if (char_taken)
        begin
            score_char(text_char, last_char);
            chars_pending--;
        end
    end

    // ------------------------------------------------------------------
    // driver: one text byte per transfer, random gaps between transfers
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin : drive_chars
        text_item_t item;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || char_taken)
        begin
            if (text_queue.size() > 0 && (steady || $urandom_range(99) >= 30))
            begin
                item = text_queue.pop_front();
                in_valid  <= 1'b1;
                text_char <= item.ch;
                last_char <= item.last;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: random back-pressure unless steady, plus one long hold-off when asked
    always @(negedge clk)
    begin
        if (stall_phase && !stall_done)
        begin
            hold_left  = LONG_HOLD;
            stall_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= steady || $urandom_range(99) >= 30;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // hand the buffered text to the driver, marking the final byte when close is set
    task automatic flush_text(input bit close);
        text_item_t item;
        int         n;
        n = text_buf.size();
        for (int k = 0; k < n; k++)
        begin
            item.ch   = text_buf[k];
            item.last = close && (k == n - 1);
            text_queue.push_back(item);
            chars_pending++;
        end
        if (n < 100)
            short_items += n;
        text_buf.delete();
    endtask

    // block is idle once every byte is in and every result is out; the extra
    // cycles cover the column update of a byte that causes no result
    task automatic wait_idle();
        while (chars_pending != 0 || awaited_scores.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(negedge clk);
        while (!reg_written);
        cfg_valid <= 1'b0;
    endtask

    function automatic bit [63:0] pack_chars(input int first);
        bit [63:0] w;
        for (int k = 0; k < 8; k++)
            w[8*k +: 8] = gen_chars[first + k];
        return w;
    endfunction

    task automatic load_pattern(input int len);
        write_reg(CFG_CHARS_LOW, pack_chars(0));
        write_reg(CFG_CHARS_HIGH, pack_chars(8));
        write_reg(CFG_PATTERN_LENGTH, 64'(len));
        gen_len = len;
    endtask

    function automatic bit [7:0] flip_case(input bit [7:0] c);
        if (c >= "a" && c <= "z" && $urandom_range(1))
            return c - 8'(CASE_OFFSET);
        if (c >= "A" && c <= "Z" && $urandom_range(1))
            return c + 8'(CASE_OFFSET);
        return c;
    endfunction

    // filler between pattern characters: mostly letters, some word breaks and digits
    function automatic bit [7:0] filler_char();
        int r;
        bit [7:0] seps[8] = '{" ", "-", "_", ".", ",", ":", "'", "/"};
        r = $urandom_range(99);
        if (r < 60)
            return 8'("a") + 8'($urandom_range(25));
        if (r < 80)
            return 8'("A") + 8'($urandom_range(25));
        if (r < 92)
            return seps[$urandom_range(7)];
        return 8'("0") + 8'($urandom_range(9));
    endfunction

    function automatic bit [7:0] pattern_char();
        int r;
        r = $urandom_range(99);
        if (r < 75)
            return flip_case(8'("a") + 8'($urandom_range(25)));
        if (r < 95)
            return filler_char();
        return 8'($urandom_range(255));
    endfunction

    task automatic choose_pattern();
        int r;
        int len;
        r = $urandom_range(99);
        if (r < 60)
            len = $urandom_range(4, 1);
        else if (r < 82)
            len = $urandom_range(10, 5);
        else if (r < 92)
            len = $urandom_range(16, 11);
        else if (r < 96)
            len = 0;
        else
            len = $urandom_range(31, 17);   // beyond the row count, never matches
        for (int k = 0; k < MAX_PATTERN; k++)
            gen_chars[k] = pattern_char();
        load_pattern(len);
    endtask

    // a text that holds the pattern as a subsequence, optionally with one character left out
    task automatic build_match(input bit broken);
        int n;
        int skip;
        n = (gen_len > MAX_PATTERN) ? MAX_PATTERN : gen_len;
        skip = (broken && n > 0) ? $urandom_range(n - 1) : -1;
        repeat ($urandom_range(4)) text_buf.push_back(filler_char());
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(99) < 40)
                repeat ($urandom_range(3, 1)) text_buf.push_back(filler_char());
            if (k != skip)
                text_buf.push_back(flip_case(gen_chars[k]));
        end
        repeat ($urandom_range(3)) text_buf.push_back(filler_char());
        if (text_buf.size() == 0)
            text_buf.push_back(filler_char());
    endtask

    task automatic build_noise();
        repeat ($urandom_range(10, 1)) text_buf.push_back(8'($urandom_range(255)));
    endtask

    task automatic build_random_text();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            build_match(1'b0);
        else if (r < 80)
            build_match(1'b1);
        else
            build_noise();
    endtask

    // a text of exactly the given length with the pattern near its head
    task automatic build_long(input int len);
        build_match(1'b0);
        while (text_buf.size() < len)
            text_buf.push_back(filler_char());
        while (text_buf.size() > len)
            void'(text_buf.pop_back());
    endtask

    task automatic send_string(input string s, input bit close);
        for (int k = 0; k < s.len(); k++)
            text_buf.push_back(s[k]);
        flush_text(close);
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------

    initial begin
        int texts;
        clear_text();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty pattern straight after reset
        send_string("a", 1'b1);
        wait_idle();

        // two-character pattern with an upper-case letter: separator bonus,
        // camel-case bonus, then a text shorter than the pattern
        gen_chars = '{default: 8'h00};
        gen_chars[0] = "a";
        gen_chars[1] = "B";
        load_pattern(2);
        send_string("a-b", 1'b1);
        send_string("xaB", 1'b1);
        send_string("a", 1'b1);
        wait_idle();

        // write to the spare index is dropped; then an oversized length
        write_reg(CFG_SPARE, '1);
        write_reg(CFG_PATTERN_LENGTH, 64'd31);
        send_string("aB", 1'b1);
        wait_idle();

        // full-length pattern of all-ones bytes
        gen_chars = '{default: 8'hFF};
        load_pattern(MAX_PATTERN);
        repeat (MAX_PATTERN) text_buf.push_back(8'hFF);
        flush_text(1'b1);
        wait_idle();

        // single zero byte pattern
        gen_chars = '{default: 8'h00};
        load_pattern(1);
        text_buf.push_back(8'h00);
        flush_text(1'b1);
        wait_idle();

        short_items = 0;
        texts = 0;
        choose_pattern();
        while (short_items < RANDOM_ITEMS)
        begin
            texts++;
            if (texts == 10)
                steady = 1'b1;
            if (texts == 40)
            begin
                wait_idle();
                steady = 1'b0;
            end

            if (texts == 60)
            begin
                // receiver goes quiet while short texts keep coming, so the
                // second finished text backs up into the input
                wait_idle();
                steady = 1'b1;
                stall_phase = 1'b1;
                repeat (12)
                begin
                    text_buf.push_back(filler_char());
                    text_buf.push_back(8'($urandom_range(255)));
                    flush_text(1'b1);
                end
                wait_idle();
                steady = 1'b0;
            end
            else if (texts == 30 || texts == 90)
            begin
                // pattern rewritten half way through a text
                build_match(1'b0);
                flush_text(1'b0);
                wait_idle();
                choose_pattern();
                build_random_text();
                flush_text(1'b1);
            end
            else if (texts == 75)
            begin
                // exactly at the text limit, then one byte beyond it
                wait_idle();
                gen_chars[0] = "q";
                gen_chars[1] = "z";
                load_pattern(2);
                build_long(MAX_TEXT);
                flush_text(1'b1);
                build_long(MAX_TEXT + 1);
                flush_text(1'b1);
            end
            else
            begin
                if ($urandom_range(7) == 0)
                begin
                    wait_idle();
                    choose_pattern();
                end
                build_random_text();
                flush_text(1'b1);
            end
        end

        wait_idle();
        repeat (10) @(negedge clk);
        if (errors == 0 && awaited_scores.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
